@@ src/gcp_pkg.sv @@
// shared types, constants and helpers of the command list packer
package gcp_pkg;

    localparam int unsigned MAX_BUFFER_WORDS = 65536;
    localparam int unsigned MAX_PARAMS       = 2048;
    localparam int unsigned MAX_RESULTS      = 6;

    localparam int unsigned OFFSET_W = 17;
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned COUNT_W  = 12;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned LIM_W    = 22;
    localparam int unsigned RCNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int unsigned RIDX_W   = $clog2(MAX_RESULTS);
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_WORDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'b1;

    localparam logic [DATA_W-1:0] FIN0_HEADER = 32'h000F_0111;
    localparam logic [DATA_W-1:0] FIN0_PARAM  = 32'h0000_0001;
    localparam logic [DATA_W-1:0] FIN1_HEADER = 32'h000F_0110;
    localparam logic [DATA_W-1:0] FIN1_PARAM  = 32'h0000_0001;
    localparam logic [DATA_W-1:0] FIN2_HEADER = 32'h000F_0010;
    localparam logic [DATA_W-1:0] FIN2_PARAM  = 32'h1234_5678;
    localparam logic [10:0]       HDR_COUNT_MASK = 11'h7ff;

    typedef enum logic [1:0] {
        OP_BEGIN    = 2'd0,
        OP_PARAM    = 2'd1,
        OP_FINALIZE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_PARAM  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_PAD    = 2'd2,
        KIND_DROP   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  write_index;
        logic [DATA_W-1:0]   write_data;
        kind_t               kind;
        logic [OFFSET_W-1:0] words_used;
    } res_t;

    // does a command of need words fit between the offset and the buffer end
    function automatic logic fits(input logic [OFFSET_W-1:0] buf_words,
                                  input logic [OFFSET_W-1:0] offset,
                                  input logic [COUNT_W-1:0]  need);
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] sum;
        if (LIM_W'(buf_words) > LIM_W'(MAX_BUFFER_WORDS)) begin
            lim = LIM_W'(MAX_BUFFER_WORDS);
        end else begin
            lim = LIM_W'(buf_words);
        end
        sum = LIM_W'(offset) + LIM_W'(need);
        return (lim != '0) && (sum <= lim);
    endfunction

    function automatic res_t make_res(input logic [OFFSET_W-1:0] offset,
                                      input logic [DATA_W-1:0]   data,
                                      input kind_t               kind);
        res_t r;
        r.write_index = offset[INDEX_W-1:0];
        r.write_data  = data;
        r.kind        = kind;
        r.words_used  = (kind == KIND_DROP) ? offset : offset + OFFSET_W'(1);
        return r;
    endfunction

endpackage

@@ src/gpu_command_list_packer_unit.sv @@
// command list packer: begin/parameter/finalize items in, buffer word writes out
//
// Each input item is decoded in the cycle it is transferred and all the buffer
// writes it causes (none to six) are loaded into a small result queue, which
// hands them out one per cycle on the m_ channel while m_ready is high. A
// parameter word gives at most one write in the steady stream, so such items go
// through at the same rate; a larger item holds the queue until its writes are
// all transferred, and the next item is taken in the cycle the last one is
// transferred. The queue depth and the per-item decode set this rate. m_last
// marks the final write of each item. The configuration port is always ready;
// writing start_offset reloads the write offset and abandons any open command.
module gpu_command_list_packer_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic [31:0]                       s_header,
    input  logic [11:0]                       s_count,
    input  logic [31:0]                       s_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [15:0]                       m_write_index,
    output logic [31:0]                       m_write_data,
    output logic [1:0]                        m_kind,
    output logic                              m_last,
    output logic [16:0]                       m_words_used,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gcp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [16:0]                       cfg_data
);

    localparam int unsigned OW = gcp_pkg::OFFSET_W;
    localparam int unsigned CW = gcp_pkg::COUNT_W;
    localparam int unsigned DW = gcp_pkg::DATA_W;
    localparam int unsigned NR = gcp_pkg::MAX_RESULTS;

    logic [OW-1:0] buffer_words_reg;
    logic [OW-1:0] write_offset_reg, write_offset_next;
    logic [DW-1:0] open_header_reg, open_header_next;
    logic [CW-1:0] words_left_reg, words_left_next;
    logic          first_pending_reg, first_pending_next;
    logic          dropping_reg, dropping_next;
    logic          needs_pad_reg, needs_pad_next;

    gcp_pkg::res_t              res_reg [NR];
    gcp_pkg::res_t              res_next [NR];
    logic [gcp_pkg::RCNT_W-1:0] rcnt_reg;
    logic [gcp_pkg::RCNT_W-1:0] n_next;

    logic in_xfer, out_xfer, cfg_xfer;

    assign m_valid   = (rcnt_reg != '0);
    assign out_xfer  = m_valid && m_ready;
    assign s_ready   = (rcnt_reg == '0) || (out_xfer && rcnt_reg == gcp_pkg::RCNT_W'(1));
    assign in_xfer   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid;

    assign m_write_index = res_reg[0].write_index;
    assign m_write_data  = res_reg[0].write_data;
    assign m_kind        = res_reg[0].kind;
    assign m_words_used  = res_reg[0].words_used;
    assign m_last        = (rcnt_reg == gcp_pkg::RCNT_W'(1));

    // decode one item into its list of buffer writes
    always_comb begin
        logic [OW-1:0]             off;
        logic [gcp_pkg::RIDX_W-1:0] n;
        logic [CW-1:0]             cm1;
        logic                      pad;
        logic                      ok;
        logic [DW-1:0]             fin_hdr [3];
        logic [DW-1:0]             fin_par [3];

        off = write_offset_reg;
        n   = '0;
        cm1 = s_count - CW'(1);
        pad = ~s_count[0];
        ok  = 1'b0;
        fin_hdr[0] = gcp_pkg::FIN0_HEADER;
        fin_hdr[1] = gcp_pkg::FIN1_HEADER;
        fin_hdr[2] = gcp_pkg::FIN2_HEADER;
        fin_par[0] = gcp_pkg::FIN0_PARAM;
        fin_par[1] = gcp_pkg::FIN1_PARAM;
        fin_par[2] = gcp_pkg::FIN2_PARAM;

        for (int i = 0; i < NR; i++) begin
            res_next[i] = res_reg[i];
        end
        open_header_next   = open_header_reg;
        words_left_next    = words_left_reg;
        first_pending_next = first_pending_reg;
        dropping_next      = dropping_reg;
        needs_pad_next     = needs_pad_reg;

        case (gcp_pkg::op_t'(s_op))
            gcp_pkg::OP_BEGIN: begin
                words_left_next    = '0;
                first_pending_next = 1'b0;
                dropping_next      = 1'b0;
                needs_pad_next     = 1'b0;
                if (s_count == '0) begin
                    // empty command carries one implied zero parameter
                    if (gcp_pkg::fits(buffer_words_reg, off, CW'(2))) begin
                        res_next[n] = gcp_pkg::make_res(off, '0, gcp_pkg::KIND_PARAM);
                        n   = n + 1'b1;
                        off = off + OW'(1);
                        res_next[n] = gcp_pkg::make_res(off, s_header, gcp_pkg::KIND_HEADER);
                        n   = n + 1'b1;
                        off = off + OW'(1);
                    end else begin
                        res_next[n] = gcp_pkg::make_res(off, '0, gcp_pkg::KIND_DROP);
                        n = n + 1'b1;
                    end
                end else begin
                    ok = (s_count <= CW'(gcp_pkg::MAX_PARAMS)) &&
                         gcp_pkg::fits(buffer_words_reg, off,
                                       s_count + CW'(1) + CW'(pad));
                    words_left_next = s_count;
                    if (!ok) begin
                        dropping_next = 1'b1;
                        res_next[n] = gcp_pkg::make_res(off, '0, gcp_pkg::KIND_DROP);
                        n = n + 1'b1;
                    end else begin
                        open_header_next   = s_header |
                            {1'b0, cm1[10:0] & gcp_pkg::HDR_COUNT_MASK, 20'd0};
                        first_pending_next = 1'b1;
                        needs_pad_next     = pad;
                    end
                end
            end
            gcp_pkg::OP_PARAM: begin
                if (words_left_reg != '0) begin
                    words_left_next = words_left_reg - CW'(1);
                    if (dropping_reg) begin
                        if (words_left_next == '0) begin
                            dropping_next = 1'b0;
                        end
                    end else begin
                        res_next[n] = gcp_pkg::make_res(off, s_word, gcp_pkg::KIND_PARAM);
                        n   = n + 1'b1;
                        off = off + OW'(1);
                        if (first_pending_reg) begin
                            res_next[n] = gcp_pkg::make_res(off, open_header_reg,
                                                            gcp_pkg::KIND_HEADER);
                            n   = n + 1'b1;
                            off = off + OW'(1);
                            first_pending_next = 1'b0;
                        end
                        if (words_left_next == '0 && needs_pad_reg) begin
                            res_next[n] = gcp_pkg::make_res(off, '0, gcp_pkg::KIND_PAD);
                            n   = n + 1'b1;
                            off = off + OW'(1);
                            needs_pad_next = 1'b0;
                        end
                    end
                end
            end
            gcp_pkg::OP_FINALIZE: begin
                words_left_next    = '0;
                first_pending_next = 1'b0;
                dropping_next      = 1'b0;
                needs_pad_next     = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    if (gcp_pkg::fits(buffer_words_reg, off, CW'(2))) begin
                        res_next[n] = gcp_pkg::make_res(off, fin_par[k],
                                                        gcp_pkg::KIND_PARAM);
                        n   = n + 1'b1;
                        off = off + OW'(1);
                        res_next[n] = gcp_pkg::make_res(off, fin_hdr[k],
                                                        gcp_pkg::KIND_HEADER);
                        n   = n + 1'b1;
                        off = off + OW'(1);
                    end else begin
                        res_next[n] = gcp_pkg::make_res(off, '0, gcp_pkg::KIND_DROP);
                        n = n + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        n_next            = gcp_pkg::RCNT_W'(n);
        write_offset_next = off;
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_words_reg  <= '0;
            write_offset_reg  <= '0;
            open_header_reg   <= '0;
            words_left_reg    <= '0;
            first_pending_reg <= 1'b0;
            dropping_reg      <= 1'b0;
            needs_pad_reg     <= 1'b0;
            rcnt_reg          <= '0;
        end else begin
            if (in_xfer) begin
                write_offset_reg  <= write_offset_next;
                open_header_reg   <= open_header_next;
                words_left_reg    <= words_left_next;
                first_pending_reg <= first_pending_next;
                dropping_reg      <= dropping_next;
                needs_pad_reg     <= needs_pad_next;
                rcnt_reg          <= n_next;
            end else if (out_xfer) begin
                rcnt_reg <= rcnt_reg - gcp_pkg::RCNT_W'(1);
            end
            if (cfg_xfer) begin
                unique case (cfg_index)
                    gcp_pkg::CFG_BUFFER_WORDS: begin
                        buffer_words_reg <= cfg_data;
                    end
                    gcp_pkg::CFG_START_OFFSET: begin
                        write_offset_reg  <= cfg_data;
                        words_left_reg    <= '0;
                        first_pending_reg <= 1'b0;
                        dropping_reg      <= 1'b0;
                        needs_pad_reg     <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result queue: load on a new item, shift down on each output transfer
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            for (int i = 0; i < NR; i++) begin
                res_reg[i] <= res_next[i];
            end
        end else if (out_xfer) begin
            for (int i = 0; i < NR - 1; i++) begin
                res_reg[i] <= res_reg[i+1];
            end
        end
    end

endmodule
